@@ rtl/core/dam_pkg.sv @@
// Shared types, constants and helpers for the DRAM address mapper.
`timescale 1ns / 1ps

package dam_pkg;

  localparam int unsigned PHYS_BITS    = 39;
  localparam int unsigned MW_BITS      = 3;
  localparam int unsigned COLUMN_BITS  = 10;
  localparam int unsigned ROW_BITS     = 16;
  localparam int unsigned BANK_BITS    = 3;
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GENERATION   = 2'd0,
    CFG_DUAL_CHANNEL = 2'd1,
    CFG_DUAL_DIMM    = 2'd2,
    CFG_DUAL_RANK    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    REQ_FORWARD = 1'b0,
    REQ_REVERSE = 1'b1
  } req_type_e;

  typedef struct packed {
    logic generation;
    logic dual_channel;
    logic dual_dimm;
    logic dual_rank;
  } dam_cfg_t;

  typedef struct packed {
    req_type_e               req_type;
    logic [PHYS_BITS-1:0]    phys;
    logic                    chan;
    logic                    dimm;
    logic                    rank;
    logic [BANK_BITS-1:0]    bank;
    logic [ROW_BITS-1:0]     row;
    logic [COLUMN_BITS-1:0]  col;
  } dam_req_t;

  typedef struct packed {
    logic [PHYS_BITS-1:0]    phys;
    logic                    chan;
    logic                    dimm;
    logic                    rank;
    logic [BANK_BITS-1:0]    bank;
    logic [ROW_BITS-1:0]     row;
    logic [COLUMN_BITS-1:0]  col;
    logic                    out_of_range;
  } dam_res_t;

  // Generation 1 channel hash over the upper address bits (bit 7 excluded).
  function automatic logic chan_hash(input logic [PHYS_BITS-1:0] a);
    return a[8] ^ a[9] ^ a[12] ^ a[13] ^ a[18] ^ a[19];
  endfunction

endpackage

@@ rtl/core/dam_xlate.sv @@
// Combinational address translation in both directions.
`timescale 1ns / 1ps

module dam_xlate import dam_pkg::*; (
  input  dam_cfg_t cfg_i,
  input  dam_req_t req_i,
  output dam_res_t res_o
);

  localparam int unsigned UpBits = PHYS_BITS - MW_BITS - COLUMN_BITS; // 26
  localparam int unsigned HiBits = ROW_BITS + 5;                       // 21

  logic [PHYS_BITS-1:0] a1;
  logic [UpBits-1:0]    u0, u1, u2;
  logic                 f_chan, f_dimm, f_rank;
  logic [BANK_BITS-1:0] f_bank;
  logic [HiBits-1:0]    t0, t1, t2, hi;
  logic [PHYS_BITS-1:0] rv;
  logic [ROW_BITS-1:0]  row;
  logic [BANK_BITS-1:0] bank;

  always_comb begin
    // Forward: channel bit comes out first, then column, then the upper part
    f_chan = 1'b0;
    a1     = req_i.phys;
    if (cfg_i.dual_channel) begin
      if (cfg_i.generation) begin
        f_chan = req_i.phys[7] ^ chan_hash(req_i.phys);
        a1     = {1'b0, req_i.phys[PHYS_BITS-1:8], req_i.phys[6:0]};
      end else begin
        f_chan = req_i.phys[6];
        a1     = {1'b0, req_i.phys[PHYS_BITS-1:7], req_i.phys[5:0]};
      end
    end
    u0     = a1[PHYS_BITS-1:MW_BITS+COLUMN_BITS];
    f_dimm = 1'b0;
    f_rank = 1'b0;
    u1     = u0;
    u2     = u0;
    if (cfg_i.generation) begin
      if (cfg_i.dual_dimm) begin
        f_dimm = u0[2];
        u1     = {1'b0, u0[UpBits-1:3], u0[1:0]};
      end
      u2 = u1;
      if (cfg_i.dual_rank) begin
        f_rank = u1[2] ^ u1[6];
        u2     = {1'b0, u1[UpBits-1:3], u1[1:0]};
      end
      f_bank = {u2[2] ^ (cfg_i.dual_rank ? u2[6] : u2[5]), u2[1] ^ u2[4], u2[0] ^ u2[3]};
    end else begin
      if (cfg_i.dual_dimm) begin
        f_dimm = u0[3];
        u1     = {1'b0, u0[UpBits-1:4], u0[2:0]};
      end
      u2 = u1;
      if (cfg_i.dual_rank) begin
        f_rank = u1[3];
        u2     = {1'b0, u1[UpBits-1:4], u1[2:0]};
      end
      f_bank = {u2[2] ^ u2[5], u2[1] ^ u2[4], u2[0] ^ u2[3]};
    end

    // Reverse: stack row, rank, DIMM and bank bits from the top down
    row  = req_i.row;
    bank = req_i.bank;
    t0   = HiBits'(row);
    if (cfg_i.generation) begin
      if (cfg_i.dual_rank) begin
        t1 = {t0[HiBits-3:0], bank[2] ^ row[3], req_i.rank ^ row[2]};
      end else begin
        t1 = {t0[HiBits-2:0], bank[2] ^ row[2]};
      end
      t2 = cfg_i.dual_dimm ? {t1[HiBits-2:0], req_i.dimm} : t1;
      hi = {t2[HiBits-3:0], bank[1] ^ row[1], bank[0] ^ row[0]};
      if (cfg_i.dual_channel) begin
        rv    = PHYS_BITS'({hi, req_i.col[9:4], 1'b0, req_i.col[3:0], {MW_BITS{1'b0}}});
        rv[7] = req_i.chan ^ chan_hash(rv);
      end else begin
        rv = PHYS_BITS'({hi, req_i.col, {MW_BITS{1'b0}}});
      end
    end else begin
      t1 = cfg_i.dual_rank ? {t0[HiBits-2:0], req_i.rank} : t0;
      t2 = cfg_i.dual_dimm ? {t1[HiBits-2:0], req_i.dimm} : t1;
      hi = {t2[HiBits-4:0], bank[2] ^ row[2], bank[1] ^ row[1], bank[0] ^ row[0]};
      if (cfg_i.dual_channel) begin
        rv = PHYS_BITS'({hi, req_i.col[9:3], req_i.chan, req_i.col[2:0], {MW_BITS{1'b0}}});
      end else begin
        rv = PHYS_BITS'({hi, req_i.col, {MW_BITS{1'b0}}});
      end
    end

    res_o = '0;
    if (req_i.req_type == REQ_REVERSE) begin
      res_o.phys = rv;
    end else begin
      res_o.chan         = f_chan;
      res_o.dimm         = f_dimm;
      res_o.rank         = f_rank;
      res_o.bank         = f_bank;
      res_o.row          = u2[ROW_BITS+2:3];
      res_o.col          = a1[MW_BITS+COLUMN_BITS-1:MW_BITS];
      res_o.out_of_range = |u2[UpBits-1:ROW_BITS+3];
    end
  end

endmodule

@@ rtl/core/dram_address_mapper_core.sv @@
// An accepted start passes through the input register and the result register to the done_o strobe with the result.
// Throughput: one transfer per cycle; busy_o is always low.
// Stages: input register, single translation pass, result register.
// Reset clears the configuration registers and the stage valid flags.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module dram_address_mapper_core import dam_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic                    cfg_wdata_i,
  input  logic                    req_type_i,
  input  logic [PHYS_BITS-1:0]    phys_in_i,
  input  logic                    chan_in_i,
  input  logic                    dimm_in_i,
  input  logic                    rank_in_i,
  input  logic [BANK_BITS-1:0]    bank_in_i,
  input  logic [ROW_BITS-1:0]     row_in_i,
  input  logic [COLUMN_BITS-1:0]  col_in_i,
  output logic                    done_o,
  output logic [PHYS_BITS-1:0]    phys_out_o,
  output logic                    chan_out_o,
  output logic                    dimm_out_o,
  output logic                    rank_out_o,
  output logic [BANK_BITS-1:0]    bank_out_o,
  output logic [ROW_BITS-1:0]     row_out_o,
  output logic [COLUMN_BITS-1:0]  col_out_o,
  output logic                    out_of_range_o
);

  dam_cfg_t cfg_q;
  dam_req_t req_q;
  logic     req_valid_q;
  dam_res_t res_d, res_q;
  logic     res_valid_q;
  logic     accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_GENERATION:   cfg_q.generation   <= cfg_wdata_i;
        CFG_DUAL_CHANNEL: cfg_q.dual_channel <= cfg_wdata_i;
        CFG_DUAL_DIMM:    cfg_q.dual_dimm    <= cfg_wdata_i;
        CFG_DUAL_RANK:    cfg_q.dual_rank    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      req_valid_q <= accept;
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.req_type <= req_type_e'(req_type_i);
      req_q.phys     <= phys_in_i;
      req_q.chan     <= chan_in_i;
      req_q.dimm     <= dimm_in_i;
      req_q.rank     <= rank_in_i;
      req_q.bank     <= bank_in_i;
      req_q.row      <= row_in_i;
      req_q.col      <= col_in_i;
    end
    if (req_valid_q) begin
      res_q <= res_d;
    end
  end

  dam_xlate u_xlate (
    .cfg_i (cfg_q),
    .req_i (req_q),
    .res_o (res_d)
  );

  assign done_o         = res_valid_q;
  assign phys_out_o     = res_q.phys;
  assign chan_out_o     = res_q.chan;
  assign dimm_out_o     = res_q.dimm;
  assign rank_out_o     = res_q.rank;
  assign bank_out_o     = res_q.bank;
  assign row_out_o      = res_q.row;
  assign col_out_o      = res_q.col;
  assign out_of_range_o = res_q.out_of_range;

`ifndef NO_ASSERTIONS
  a_accept_two_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted transfer did not produce a result after two cycles");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_valid_q |=> !done_o)
    else $error("result strobe without a request in the translation stage");

  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (phys_out_o == '0) ||
               (!out_of_range_o && row_out_o == '0 && col_out_o == '0 &&
                bank_out_o == '0 && !chan_out_o && !dimm_out_o && !rank_out_o))
    else $error("result carries both physical and DRAM coordinates");
`endif

endmodule

@@ bench/dam_map_checker.sv @@
// Checker for the DRAM address mapper: tracks configuration, predicts each translation, compares.
`timescale 1ns / 1ps

module dam_map_checker import dam_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic                    cfg_wdata_i,
  input  logic                    req_type_i,
  input  logic [PHYS_BITS-1:0]    phys_in_i,
  input  logic                    chan_in_i,
  input  logic                    dimm_in_i,
  input  logic                    rank_in_i,
  input  logic [BANK_BITS-1:0]    bank_in_i,
  input  logic [ROW_BITS-1:0]     row_in_i,
  input  logic [COLUMN_BITS-1:0]  col_in_i,
  input  logic                    done_i,
  input  logic [PHYS_BITS-1:0]    phys_out_i,
  input  logic                    chan_out_i,
  input  logic                    dimm_out_i,
  input  logic                    rank_out_i,
  input  logic [BANK_BITS-1:0]    bank_out_i,
  input  logic [ROW_BITS-1:0]     row_out_i,
  input  logic [COLUMN_BITS-1:0]  col_out_i,
  input  logic                    out_of_range_i,
  output int unsigned             mismatch_count_o,
  output int unsigned             outstanding_o
);

  dam_cfg_t mirror_cfg;
  dam_res_t expected_maps[$];

  // Remove bit n and close the gap.
  function automatic logic [63:0] squeeze_bit(input logic [63:0] x, input int n);
    logic [63:0] low_mask;
    low_mask = (64'd1 << n) - 64'd1;
    return (x & low_mask) | ((x >> (n + 1)) << n);
  endfunction

  function automatic logic upper_hash(input logic [63:0] a);
    return a[8] ^ a[9] ^ a[12] ^ a[13] ^ a[18] ^ a[19];
  endfunction

  function automatic dam_res_t decode_phys(input dam_cfg_t c, input logic [PHYS_BITS-1:0] phys);
    dam_res_t    res;
    logic [63:0] a;
    res = '0;
    a = '0;
    a[PHYS_BITS-1:0] = phys;
    if (c.dual_channel) begin
      if (c.generation) begin
        res.chan = a[7] ^ upper_hash(a);
        a = squeeze_bit(a, 7);
      end else begin
        res.chan = a[6];
        a = squeeze_bit(a, 6);
      end
    end
    a = a >> MW_BITS;
    res.col = a[COLUMN_BITS-1:0];
    a = a >> COLUMN_BITS;
    if (c.generation) begin
      if (c.dual_dimm) begin
        res.dimm = a[2];
        a = squeeze_bit(a, 2);
      end
      if (c.dual_rank) begin
        res.rank = a[2] ^ a[6];
        a = squeeze_bit(a, 2);
      end
      res.bank = {a[2] ^ (c.dual_rank ? a[6] : a[5]), a[1] ^ a[4], a[0] ^ a[3]};
    end else begin
      if (c.dual_dimm) begin
        res.dimm = a[3];
        a = squeeze_bit(a, 3);
      end
      if (c.dual_rank) begin
        res.rank = a[3];
        a = squeeze_bit(a, 3);
      end
      res.bank = {a[2] ^ a[5], a[1] ^ a[4], a[0] ^ a[3]};
    end
    a = a >> BANK_BITS;
    res.row = a[ROW_BITS-1:0];
    a = a >> ROW_BITS;
    res.out_of_range = (a != 64'd0);
    return res;
  endfunction

  function automatic logic [PHYS_BITS-1:0] rebuild_phys(input dam_cfg_t c, input dam_req_t q);
    logic [63:0] r;
    r = '0;
    r[ROW_BITS-1:0] = q.row;
    if (c.generation) begin
      if (c.dual_rank) begin
        r = {r[62:0], q.bank[2] ^ q.row[3]};
        r = {r[62:0], q.rank ^ q.row[2]};
      end else begin
        r = {r[62:0], q.bank[2] ^ q.row[2]};
      end
      if (c.dual_dimm) r = {r[62:0], q.dimm};
      r = {r[62:0], q.bank[1] ^ q.row[1]};
      r = {r[62:0], q.bank[0] ^ q.row[0]};
      if (c.dual_channel) begin
        // column split around the hashed channel bit at address bit 7
        r = {r[57:0], q.col[9:4]};
        r = {r[62:0], 1'b0};
        r = {r[59:0], q.col[3:0]};
        r = r << MW_BITS;
        r[7] = q.chan ^ upper_hash(r);
      end else begin
        r = {r[53:0], q.col};
        r = r << MW_BITS;
      end
    end else begin
      if (c.dual_rank) r = {r[62:0], q.rank};
      if (c.dual_dimm) r = {r[62:0], q.dimm};
      r = {r[62:0], q.bank[2] ^ q.row[2]};
      r = {r[62:0], q.bank[1] ^ q.row[1]};
      r = {r[62:0], q.bank[0] ^ q.row[0]};
      if (c.dual_channel) begin
        r = {r[56:0], q.col[9:3]};
        r = {r[62:0], q.chan};
        r = {r[60:0], q.col[2:0]};
      end else begin
        r = {r[53:0], q.col};
      end
      r = r << MW_BITS;
    end
    return r[PHYS_BITS-1:0];
  endfunction

  function automatic dam_res_t map_request(input dam_cfg_t c, input dam_req_t q);
    dam_res_t res;
    if (q.req_type == REQ_FORWARD) begin
      res = decode_phys(c, q.phys);
    end else begin
      res = '0;
      res.phys = rebuild_phys(c, q);
    end
    return res;
  endfunction

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatch_count_o++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dam_req_t req;
    dam_res_t want;
    if (!rst_ni) begin
      mirror_cfg = '0;
      expected_maps.delete();
      mismatch_count_o = 0;
      outstanding_o = 0;
    end else begin
      if (done_i) begin
        if (expected_maps.size() == 0) begin
          mismatch_count_o++;
          $error("result transfer with no request outstanding");
        end else begin
          want = expected_maps.pop_front();
          compare_field("phys_out", 64'(want.phys), 64'(phys_out_i));
          compare_field("chan_out", 64'(want.chan), 64'(chan_out_i));
          compare_field("dimm_out", 64'(want.dimm), 64'(dimm_out_i));
          compare_field("rank_out", 64'(want.rank), 64'(rank_out_i));
          compare_field("bank_out", 64'(want.bank), 64'(bank_out_i));
          compare_field("row_out", 64'(want.row), 64'(row_out_i));
          compare_field("col_out", 64'(want.col), 64'(col_out_i));
          compare_field("out_of_range", 64'(want.out_of_range), 64'(out_of_range_i));
        end
      end
      if (start_i && !busy_i) begin
        req.req_type = req_type_e'(req_type_i);
        req.phys     = phys_in_i;
        req.chan     = chan_in_i;
        req.dimm     = dimm_in_i;
        req.rank     = rank_in_i;
        req.bank     = bank_in_i;
        req.row      = row_in_i;
        req.col      = col_in_i;
        expected_maps.push_back(map_request(mirror_cfg, req));
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_GENERATION:   mirror_cfg.generation   = cfg_wdata_i;
          CFG_DUAL_CHANNEL: mirror_cfg.dual_channel = cfg_wdata_i;
          CFG_DUAL_DIMM:    mirror_cfg.dual_dimm    = cfg_wdata_i;
          CFG_DUAL_RANK:    mirror_cfg.dual_rank    = cfg_wdata_i;
          default: ;
        endcase
      end
      outstanding_o = expected_maps.size();
    end
  end

endmodule

@@ bench/tb.sv @@
// Testbench top for the DRAM address mapper: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module tb;
  import dam_pkg::*;

  localparam int unsigned LATENCY        = 2;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_SET  = 68;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic                    cfg_wdata_i;
  logic                    req_type_i;
  logic [PHYS_BITS-1:0]    phys_in_i;
  logic                    chan_in_i;
  logic                    dimm_in_i;
  logic                    rank_in_i;
  logic [BANK_BITS-1:0]    bank_in_i;
  logic [ROW_BITS-1:0]     row_in_i;
  logic [COLUMN_BITS-1:0]  col_in_i;
  logic                    done_o;
  logic [PHYS_BITS-1:0]    phys_out_o;
  logic                    chan_out_o;
  logic                    dimm_out_o;
  logic                    rank_out_o;
  logic [BANK_BITS-1:0]    bank_out_o;
  logic [ROW_BITS-1:0]     row_out_o;
  logic [COLUMN_BITS-1:0]  col_out_o;
  logic                    out_of_range_o;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned idle_cycles;
  dam_req_t    corner_reqs[$];

  dram_address_mapper_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_type_i),
    .phys_in_i      (phys_in_i),
    .chan_in_i      (chan_in_i),
    .dimm_in_i      (dimm_in_i),
    .rank_in_i      (rank_in_i),
    .bank_in_i      (bank_in_i),
    .row_in_i       (row_in_i),
    .col_in_i       (col_in_i),
    .done_o         (done_o),
    .phys_out_o     (phys_out_o),
    .chan_out_o     (chan_out_o),
    .dimm_out_o     (dimm_out_o),
    .rank_out_o     (rank_out_o),
    .bank_out_o     (bank_out_o),
    .row_out_o      (row_out_o),
    .col_out_o      (col_out_o),
    .out_of_range_o (out_of_range_o)
  );

  dam_map_checker u_map_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_type_i       (req_type_i),
    .phys_in_i        (phys_in_i),
    .chan_in_i        (chan_in_i),
    .dimm_in_i        (dimm_in_i),
    .rank_in_i        (rank_in_i),
    .bank_in_i        (bank_in_i),
    .row_in_i         (row_in_i),
    .col_in_i         (col_in_i),
    .done_i           (done_o),
    .phys_out_i       (phys_out_o),
    .chan_out_i       (chan_out_o),
    .dimm_out_i       (dimm_out_o),
    .rank_out_i       (rank_out_o),
    .bank_out_i       (bank_out_o),
    .row_out_i        (row_out_o),
    .col_out_i        (col_out_o),
    .out_of_range_i   (out_of_range_o),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("dram_address_mapper_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic dam_req_t fwd_req(input logic [PHYS_BITS-1:0] phys);
    dam_req_t q;
    q = '0;
    q.req_type = REQ_FORWARD;
    q.phys = phys;
    return q;
  endfunction

  function automatic dam_req_t rev_req(input logic chan, input logic dimm, input logic rank,
                                       input logic [BANK_BITS-1:0] bank,
                                       input logic [ROW_BITS-1:0] row,
                                       input logic [COLUMN_BITS-1:0] col);
    dam_req_t q;
    q = '0;
    q.req_type = REQ_REVERSE;
    q.chan = chan;
    q.dimm = dimm;
    q.rank = rank;
    q.bank = bank;
    q.row  = row;
    q.col  = col;
    return q;
  endfunction

  // Mostly addresses inside the configured geometry, some just above it, a few anywhere.
  function automatic dam_req_t random_req(input dam_cfg_t c);
    dam_req_t    q;
    logic [63:0] raw;
    int unsigned span;
    int unsigned pick;
    raw  = {$urandom, $urandom};
    span = 32 + c.dual_channel + c.dual_dimm + c.dual_rank;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      raw = raw & ((64'd1 << span) - 64'd1);
    else if (pick < 85)
      raw = raw & ((64'd1 << (span + $urandom_range(0, 2))) - 64'd1);
    q.req_type = $urandom_range(0, 1) ? REQ_REVERSE : REQ_FORWARD;
    q.phys = raw[PHYS_BITS-1:0];
    q.chan = 1'($urandom_range(0, 1));
    q.dimm = 1'($urandom_range(0, 1));
    q.rank = 1'($urandom_range(0, 1));
    q.bank = BANK_BITS'($urandom_range(0, 7));
    q.row  = ROW_BITS'($urandom_range(0, 65535));
    q.col  = COLUMN_BITS'($urandom_range(0, 1023));
    return q;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Presents one request and returns at the edge where it transfers.
  task automatic issue_request(input dam_req_t q);
    start_i    <= 1'b1;
    req_type_i <= q.req_type;
    phys_in_i  <= q.phys;
    chan_in_i  <= q.chan;
    dimm_in_i  <= q.dimm;
    rank_in_i  <= q.rank;
    bank_in_i  <= q.bank;
    row_in_i   <= q.row;
    col_in_i   <= q.col;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
  endtask

  task automatic send_with_gap(input dam_req_t q, input bit quiet);
    int unsigned gap;
    issue_request(q);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_mappings();
    start_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (LATENCY + 1) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic program_mapping(input dam_cfg_t c);
    write_reg(CFG_GENERATION, c.generation);
    write_reg(CFG_DUAL_CHANNEL, c.dual_channel);
    write_reg(CFG_DUAL_DIMM, c.dual_dimm);
    write_reg(CFG_DUAL_RANK, c.dual_rank);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    dam_cfg_t setting;
    bit       quiet;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_GENERATION;
    cfg_wdata_i = 1'b0;
    req_type_i  = REQ_FORWARD;
    phys_in_i   = '0;
    chan_in_i   = 1'b0;
    dimm_in_i   = 1'b0;
    rank_in_i   = 1'b0;
    bank_in_i   = '0;
    row_in_i    = '0;
    col_in_i    = '0;

    // forward corners: zero, all ones, edges of the smallest and largest geometry, three bit patterns
    corner_reqs.push_back(fwd_req('0));
    corner_reqs.push_back(fwd_req({PHYS_BITS{1'b1}}));
    corner_reqs.push_back(fwd_req(39'hFFFF_FFFF));
    corner_reqs.push_back(fwd_req(39'h1_0000_0000));
    corner_reqs.push_back(fwd_req(39'h7_FFFF_FFFF));
    corner_reqs.push_back(fwd_req(39'h40_0000_0000));
    corner_reqs.push_back(fwd_req(39'h55_5555_5555));
    corner_reqs.push_back(fwd_req(39'h2A_AAAA_AAAA));
    corner_reqs.push_back(fwd_req(39'h0_000C_33C0));
    // reverse corners; single-geometry coordinates set so they must be ignored
    corner_reqs.push_back(rev_req(1'b0, 1'b0, 1'b0, 3'd0, 16'h0000, 10'h000));
    corner_reqs.push_back(rev_req(1'b1, 1'b1, 1'b1, 3'd7, 16'hFFFF, 10'h3FF));
    corner_reqs.push_back(rev_req(1'b1, 1'b0, 1'b1, 3'd5, 16'h000F, 10'h000));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration first, then everything dual with the hashed scheme
    foreach (corner_reqs[i]) send_with_gap(corner_reqs[i], 1'b0);
    drain_mappings();
    program_mapping(4'b1111);
    foreach (corner_reqs[i]) send_with_gap(corner_reqs[i], 1'b0);
    drain_mappings();

    for (int s = 0; s < 16; s++) begin
      setting = dam_cfg_t'(s[3:0]);
      quiet = ($urandom_range(0, 3) == 0);
      program_mapping(setting);
      for (int n = 0; n < ITEMS_PER_SET; n++)
        send_with_gap(random_req(setting), quiet);
      drain_mappings();
    end

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("dram_address_mapper_core verification clean");
    end else begin
      $display("dram_address_mapper_core verification failed");
    end
    $finish;
  end

endmodule
